// ----- rtl/ami_pkg.sv -----
package ami_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int PW        = 2 * DW;
    localparam int CW        = PW + 1;
    localparam int DETW      = CW + DW + 2;
    localparam int RW        = DETW + 1;
    localparam int QW        = 2 * FRAC_BITS;
    localparam int NCOF      = 9;
    localparam int NLANE     = 3;

    localparam logic [1:0] ROW_FIRST = 2'd0;
    localparam logic [1:0] ROW_LAST  = 2'd2;

    localparam logic [DW-1:0] SAT_POS = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] SAT_NEG = {1'b1, {(DW-1){1'b0}}};

    // operand indexes of each cofactor: adj = m[a]*m[b] - m[c]*m[d]
    localparam int COF_IDX [NCOF][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    typedef struct packed {
        logic signed [DW-1:0] m00;
        logic signed [DW-1:0] m01;
        logic signed [DW-1:0] m02;
        logic signed [DW-1:0] m10;
        logic signed [DW-1:0] m11;
        logic signed [DW-1:0] m12;
        logic signed [DW-1:0] m20;
        logic signed [DW-1:0] m21;
        logic signed [DW-1:0] m22;
        logic signed [DW-1:0] tx;
        logic signed [DW-1:0] ty;
        logic signed [DW-1:0] tz;
    } t_req;

    typedef struct packed {
        logic [1:0]           row;
        logic signed [DW-1:0] inv_c0;
        logic signed [DW-1:0] inv_c1;
        logic signed [DW-1:0] inv_c2;
        logic signed [DW-1:0] inv_t;
        logic                 singular;
        logic                 last;
    } t_rsp;

    typedef struct packed {
        logic [NCOF-1:0][CW-1:0]  adj;
        logic [NCOF-1:0][DW-1:0]  se;
        logic [DETW-1:0]          dmag;
        logic                     dneg;
        logic                     sing;
        logic [NLANE-1:0][DW-1:0] t;
    } t_item;

    typedef struct packed {
        logic [1:0]               row;
        logic                     sing;
        logic [NLANE-1:0][DW-1:0] se;
        logic [NLANE-1:0][DW-1:0] t;
    } t_side;

    function automatic logic signed [PW-1:0] smul(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
        smul = a * b;
    endfunction

    function automatic logic [DW-1:0] sat32(input logic neg, input logic [RW-1:0] mag);
        logic [DW-1:0] lim;
        lim = SAT_POS;
        if (!neg) begin
            sat32 = (mag > {{(RW-DW){1'b0}}, lim}) ? SAT_POS : mag[DW-1:0];
        end else begin
            sat32 = (mag > {{(RW-DW){1'b0}}, SAT_NEG}) ? SAT_NEG : (~mag[DW-1:0]) + 1'b1;
        end
    endfunction

endpackage

// ----- rtl/ami_front.sv -----
module ami_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_valid,
    input  ami_pkg::t_req i_req,
    output logic          o_valid,
    output ami_pkg::t_item o_item
);
    import ami_pkg::*;

    logic [NCOF-1:0][DW-1:0] mm;
    logic [NLANE-1:0][DW-1:0] tt;

    logic [NCOF-1:0][1:0][PW-1:0] r1_p;
    logic [NLANE-1:0][DW-1:0]     r1_m0, r1_t;
    logic                         r1_v;

    logic [NCOF-1:0][CW-1:0]  r2_adj;
    logic [NLANE-1:0][DW-1:0] r2_m0, r2_t;
    logic                     r2_v;

    logic [NLANE-1:0][CW-1:0] r3_lo, r3_hi;
    logic [NCOF-1:0][CW-1:0]  r3_adj;
    logic [NCOF-1:0][DW-1:0]  r3_se, n3_se;
    logic [NLANE-1:0][DW-1:0] r3_t;
    logic                     r3_v;

    logic [NLANE-1:0][DETW-1:0] r4_term, n4_term;
    logic [NCOF-1:0][CW-1:0]    r4_adj;
    logic [NCOF-1:0][DW-1:0]    r4_se;
    logic [NLANE-1:0][DW-1:0]   r4_t;
    logic                       r4_v;

    t_item n5_item, r5_item;
    logic  r5_v;

    assign mm = {i_req.m22, i_req.m21, i_req.m20, i_req.m12, i_req.m11, i_req.m10,
                 i_req.m02, i_req.m01, i_req.m00};
    assign tt = {i_req.tz, i_req.ty, i_req.tx};

    always_comb begin
        logic          neg;
        logic [CW-1:0] mag;
        logic [CW-1:0] sh;
        for (int k = 0; k < NCOF; k++) begin
            neg = r2_adj[k][CW-1];
            mag = neg ? (~r2_adj[k]) + 1'b1 : r2_adj[k];
            sh  = mag >> FRAC_BITS;
            n3_se[k] = sat32(neg, {{(RW-CW){1'b0}}, sh});
        end
    end

    always_comb begin
        logic signed [DETW-1:0] th, tl;
        for (int j = 0; j < NLANE; j++) begin
            th = $signed(r3_hi[j]);
            tl = $signed(r3_lo[j]);
            n4_term[j] = (th <<< DW) + tl;
        end
    end

    always_comb begin
        logic signed [DETW-1:0] det;
        det = $signed(r4_term[0]) + $signed(r4_term[1]) + $signed(r4_term[2]);
        n5_item.adj  = r4_adj;
        n5_item.se   = r4_se;
        n5_item.t    = r4_t;
        n5_item.dneg = det[DETW-1];
        n5_item.dmag = det[DETW-1] ? (~det) + 1'b1 : det;
        n5_item.sing = (det == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (i_adv) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < NCOF; k++) begin
                r1_p[k][0] <= smul(mm[COF_IDX[k][0]], mm[COF_IDX[k][1]]);
                r1_p[k][1] <= smul(mm[COF_IDX[k][2]], mm[COF_IDX[k][3]]);
                r2_adj[k]  <= $signed(r1_p[k][0]) - $signed(r1_p[k][1]);
            end
            r1_m0 <= mm[NLANE-1:0];
            r1_t  <= tt;
            r2_m0 <= r1_m0;
            r2_t  <= r1_t;
            // det = adj00*m00 + adj10*m01 + adj20*m02, split into 33x32 halves
            for (int j = 0; j < NLANE; j++) begin
                r3_lo[j] <= $signed({1'b0, r2_adj[3*j][DW-1:0]}) * $signed(r2_m0[j]);
                r3_hi[j] <= $signed(r2_adj[3*j][CW-1:DW]) * $signed(r2_m0[j]);
            end
            r3_adj  <= r2_adj;
            r3_se   <= n3_se;
            r3_t    <= r2_t;
            r4_term <= n4_term;
            r4_adj  <= r3_adj;
            r4_se   <= r3_se;
            r4_t    <= r3_t;
            r5_item <= n5_item;
        end
    end

    assign o_valid = r5_v;
    assign o_item  = r5_item;

endmodule

// ----- rtl/ami_div.sv -----
module ami_div (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_en,
    input  logic                                       i_valid,
    input  logic [ami_pkg::NLANE-1:0][ami_pkg::CW-1:0] i_a,
    input  logic [ami_pkg::NLANE-1:0]                  i_neg,
    input  logic [ami_pkg::DETW-1:0]                   i_dmag,
    input  ami_pkg::t_side                             i_side,
    output logic                                       o_valid,
    output logic [ami_pkg::NLANE-1:0][ami_pkg::QW-1:0] o_q,
    output logic [ami_pkg::NLANE-1:0]                  o_ovf,
    output logic [ami_pkg::NLANE-1:0]                  o_neg,
    output ami_pkg::t_side                             o_side
);
    import ami_pkg::*;

    logic [QW:0][NLANE-1:0][RW-1:0] r_rem;
    logic [QW:0][NLANE-1:0][QW-1:0] r_q;
    logic [QW:0][NLANE-1:0]         r_ovf, r_neg;
    logic [QW:0][DETW-1:0]          r_d;
    logic [QW:0]                    r_v;
    t_side                          r_side [QW+1];

    logic [QW-1:0][NLANE-1:0][RW-1:0] n_rem;
    logic [QW-1:0][NLANE-1:0][QW-1:0] n_q;

    // one quotient bit per stage, shifted-in numerator bits are zero
    always_comb begin
        logic [RW-1:0] sh;
        logic          ge;
        for (int s = 0; s < QW; s++) begin
            for (int l = 0; l < NLANE; l++) begin
                sh = {r_rem[s][l][RW-2:0], 1'b0};
                ge = (sh >= {1'b0, r_d[s]});
                n_rem[s][l] = ge ? sh - {1'b0, r_d[s]} : sh;
                n_q[s][l]   = {r_q[s][l][QW-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QW-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < NLANE; l++) begin
                r_rem[0][l] <= {{(RW-CW){1'b0}}, i_a[l]};
                r_q[0][l]   <= '0;
                r_ovf[0][l] <= ({{(RW-CW){1'b0}}, i_a[l]} >= {1'b0, i_dmag});
                r_neg[0][l] <= i_neg[l];
            end
            r_d[0]    <= i_dmag;
            r_side[0] <= i_side;
            for (int s = 0; s < QW; s++) begin
                r_rem[s+1]  <= n_rem[s];
                r_q[s+1]    <= n_q[s];
                r_ovf[s+1]  <= r_ovf[s];
                r_neg[s+1]  <= r_neg[s];
                r_d[s+1]    <= r_d[s];
                r_side[s+1] <= r_side[s];
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_q     = r_q[QW];
    assign o_ovf   = r_ovf[QW];
    assign o_neg   = r_neg[QW];
    assign o_side  = r_side[QW];

endmodule

// ----- rtl/affine_matrix_inverse.sv -----
// Inverts one 3D affine transform per request (3x3 linear part plus translation, signed
// Q16.16) and returns the inverse as three row responses, row 0 first, with last set on
// row 2 and singular set on all three when the determinant is zero (entries are then
// the undivided adjugate). A new request is taken only when the row sequencer is idle or
// sending its last row; it sends one row per cycle, unless the output stalls, into a
// 32-stage restoring divider with three lanes.
module affine_matrix_inverse (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ami_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output ami_pkg::t_rsp o_rsp
);
    import ami_pkg::*;

    logic  en, front_adv;
    logic  f_valid;
    t_item f_item;

    t_item      r_sitem;
    logic [1:0] r_srow;
    logic       r_sv;

    logic [NLANE-1:0][CW-1:0] d_a;
    logic [NLANE-1:0]         d_neg;
    t_side                    d_side;

    logic                     q_valid;
    logic [NLANE-1:0][QW-1:0] q_q;
    logic [NLANE-1:0]         q_ovf, q_neg;
    t_side                    q_side;

    logic [NLANE-1:0][DW-1:0] r_e, n_e;
    t_side                    r_eside;
    logic                     r_ev;

    logic [NLANE-1:0][PW-1:0] r_p;
    logic [NLANE-1:0][DW-1:0] r_pe;
    t_side                    r_pside;
    logic                     r_pv;

    t_rsp r_out, n_out;
    logic r_ov;

    assign en        = !r_ov || i_ready;
    assign front_adv = en && (!r_sv || r_srow == ROW_LAST);
    assign o_ready   = front_adv && i_rst_n;

    ami_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (front_adv),
        .i_valid (i_valid),
        .i_req   (i_req),
        .o_valid (f_valid),
        .o_item  (f_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv   <= 1'b0;
            r_srow <= ROW_FIRST;
        end else if (front_adv) begin
            r_sv   <= f_valid;
            r_srow <= ROW_FIRST;
        end else if (en && r_sv) begin
            r_srow <= r_srow + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (front_adv) begin
            r_sitem <= f_item;
        end
    end

    // pick the current row of the adjugate
    always_comb begin
        logic [3:0]    idx;
        logic [CW-1:0] a;
        d_side.row  = r_srow;
        d_side.sing = r_sitem.sing;
        d_side.t    = r_sitem.t;
        for (int c = 0; c < NLANE; c++) begin
            idx = ({2'b00, r_srow} * 4'd3) + 4'(c);
            a   = r_sitem.adj[idx];
            d_a[c]       = a[CW-1] ? (~a) + 1'b1 : a;
            d_neg[c]     = a[CW-1] ^ r_sitem.dneg;
            d_side.se[c] = r_sitem.se[idx];
        end
    end

    ami_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_sv),
        .i_a     (d_a),
        .i_neg   (d_neg),
        .i_dmag  (r_sitem.dmag),
        .i_side  (d_side),
        .o_valid (q_valid),
        .o_q     (q_q),
        .o_ovf   (q_ovf),
        .o_neg   (q_neg),
        .o_side  (q_side)
    );

    always_comb begin
        for (int c = 0; c < NLANE; c++) begin
            n_e[c] = q_side.sing ? q_side.se[c]
                   : sat32(q_neg[c], {{(RW-QW-1){1'b0}}, q_ovf[c], q_q[c]});
        end
    end

    always_comb begin
        logic signed [PW+1:0] s;
        logic [PW+1:0]        mag;
        logic [PW+1:0]        sh;
        s   = $signed(r_p[0]) + $signed(r_p[1]) + $signed(r_p[2]);
        mag = s[PW+1] ? (~s) + 1'b1 : s;
        sh  = mag >> FRAC_BITS;
        n_out.row      = r_pside.row;
        n_out.inv_c0   = r_pe[0];
        n_out.inv_c1   = r_pe[1];
        n_out.inv_c2   = r_pe[2];
        // translation is the negated sum
        n_out.inv_t    = sat32(!s[PW+1] && (s != '0), {{(RW-PW-2){1'b0}}, sh});
        n_out.singular = r_pside.sing;
        n_out.last     = (r_pside.row == ROW_LAST);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= 1'b0;
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_ev <= q_valid;
            r_pv <= r_ev;
            r_ov <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e     <= n_e;
            r_eside <= q_side;
            for (int c = 0; c < NLANE; c++) begin
                r_p[c] <= smul(r_e[c], r_eside.t[c]);
            end
            r_pe    <= r_e;
            r_pside <= r_eside;
            r_out   <= n_out;
        end
    end

    assign o_valid = r_ov;
    assign o_rsp   = r_out;

endmodule

// ----- tb/sv/tb_affine_matrix_inverse.sv -----
`timescale 1ns / 1ps

module tb_affine_matrix_inverse;
    import ami_pkg::*;

    typedef logic signed [255:0] wide_t;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_ready;
    t_req  i_req;
    logic  o_valid;
    logic  i_ready;
    t_rsp  o_rsp;

    t_rsp  rows_due[$];
    int    mismatches;
    int    rows_seen;
    int    singular_seen;
    int    stall_left;
    bit    quiet;

    affine_matrix_inverse dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #5ms;
        $display("tb_affine_matrix_inverse NOT OK");
        $finish;
    end

    function automatic wide_t wabs(input wide_t v);
        wabs = (v < 0) ? -v : v;
    endfunction

    function automatic logic [DW-1:0] clamp32(input logic neg, input wide_t mag);
        if (!neg) begin
            clamp32 = (mag > wide_t'(64'h7FFF_FFFF)) ? SAT_POS : mag[DW-1:0];
        end else begin
            clamp32 = (mag > wide_t'(64'h8000_0000)) ? SAT_NEG : (~mag[DW-1:0]) + 1'b1;
        end
    endfunction

    function automatic logic [DW-1:0] shrink(input wide_t v);
        shrink = clamp32(v < 0, wabs(v) >>> FRAC_BITS);
    endfunction

    task automatic push_inverse(input t_req q);
        wide_t m[9];
        wide_t tv[3];
        wide_t adj[9];
        wide_t det;
        wide_t s;
        logic [DW-1:0] e[3];
        logic sing;
        t_rsp rsp;
        m = '{wide_t'(q.m00), wide_t'(q.m01), wide_t'(q.m02),
              wide_t'(q.m10), wide_t'(q.m11), wide_t'(q.m12),
              wide_t'(q.m20), wide_t'(q.m21), wide_t'(q.m22)};
        tv = '{wide_t'(q.tx), wide_t'(q.ty), wide_t'(q.tz)};
        adj[0] = m[4] * m[8] - m[5] * m[7];
        adj[1] = m[2] * m[7] - m[1] * m[8];
        adj[2] = m[1] * m[5] - m[2] * m[4];
        adj[3] = m[5] * m[6] - m[3] * m[8];
        adj[4] = m[0] * m[8] - m[2] * m[6];
        adj[5] = m[2] * m[3] - m[0] * m[5];
        adj[6] = m[3] * m[7] - m[4] * m[6];
        adj[7] = m[1] * m[6] - m[0] * m[7];
        adj[8] = m[0] * m[4] - m[1] * m[3];
        det = adj[0] * m[0] + adj[3] * m[1] + adj[6] * m[2];
        sing = (det == 0);
        if (sing) singular_seen++;
        for (int r = 0; r < 3; r++) begin
            s = 0;
            for (int c = 0; c < 3; c++) begin
                if (sing) begin
                    e[c] = shrink(adj[r * 3 + c]);
                end else begin
                    e[c] = clamp32((adj[r * 3 + c] < 0) != (det < 0),
                                   (wabs(adj[r * 3 + c]) <<< QW) / wabs(det));
                end
                s = s + wide_t'($signed(e[c])) * tv[c];
            end
            rsp.row      = 2'(r);
            rsp.inv_c0   = e[0];
            rsp.inv_c1   = e[1];
            rsp.inv_c2   = e[2];
            rsp.inv_t    = shrink(-s);
            rsp.singular = sing;
            rsp.last     = (2'(r) == ROW_LAST);
            rows_due.push_back(rsp);
        end
    endtask

    task automatic send_req(input t_req q, input bit typed, input t_rsp known[3]);
        i_valid <= 1'b1;
        i_req   <= q;
        do @(posedge i_clk); while (!o_ready);
        if (typed) begin
            for (int r = 0; r < 3; r++) rows_due.push_back(known[r]);
        end else begin
            push_inverse(q);
        end
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                rows_seen++;
                if (rows_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected response %p", o_rsp);
                end else begin
                    want = rows_due.pop_front();
                    if (o_rsp.row !== want.row || o_rsp.inv_c0 !== want.inv_c0 ||
                        o_rsp.inv_c1 !== want.inv_c1 || o_rsp.inv_c2 !== want.inv_c2 ||
                        o_rsp.inv_t !== want.inv_t || o_rsp.singular !== want.singular ||
                        o_rsp.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected %p", want);
                            $display("          actual   %p", o_rsp);
                        end
                    end
                end
            end
            if (quiet) begin
                i_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_ready    <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                stall_left <= $urandom_range(0, 8);
                i_ready    <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    function automatic t_req diag(input logic [31:0] a, input logic [31:0] b,
                                  input logic [31:0] c, input logic [31:0] t);
        t_req q;
        q = '0;
        q.m00 = a;
        q.m11 = b;
        q.m22 = c;
        q.tx  = t;
        q.ty  = -t;
        q.tz  = t;
        return q;
    endfunction

    function automatic logic [31:0] fixed_small();
        return 32'($signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000);
    endfunction

    function automatic t_req rand_req(input int kind);
        t_req q;
        q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if (kind >= 4) begin
            q.m00 = fixed_small(); q.m01 = fixed_small(); q.m02 = fixed_small();
            q.m10 = fixed_small(); q.m11 = fixed_small(); q.m12 = fixed_small();
            q.m20 = fixed_small(); q.m21 = fixed_small(); q.m22 = fixed_small();
        end
        if (kind == 8) begin
            q.m20 = q.m00; q.m21 = q.m01; q.m22 = q.m02;
        end
        if (kind == 9) begin
            q.m01 = '0; q.m02 = '0; q.m10 = '0; q.m12 = '0; q.m20 = '0; q.m21 = '0;
        end
        return q;
    endfunction

    typedef struct {
        t_req q;
        bit   typed;
        t_rsp known[3];
    } stim_t;

    initial begin
        stim_t plan[$];
        stim_t st;
        t_req  q;
        int    waited;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_req      = '0;
        i_ready    = 1'b0;
        quiet      = 1'b0;
        stall_left = 0;
        mismatches = 0;
        rows_seen  = 0;
        singular_seen = 0;

        // identity, inverse translation is minus t
        st.q = diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000);
        st.typed = 1'b1;
        st.known[0] = '{ROW_FIRST, 32'h0001_0000, 32'h0, 32'h0, -32'sh0002_0000, 1'b0, 1'b0};
        st.known[1] = '{2'd1, 32'h0, 32'h0001_0000, 32'h0, 32'sh0002_0000, 1'b0, 1'b0};
        st.known[2] = '{ROW_LAST, 32'h0, 32'h0, 32'h0001_0000, -32'sh0002_0000, 1'b0, 1'b1};
        plan.push_back(st);
        // all zero: singular, all zero entries
        st.q = '0;
        st.known[0] = '{ROW_FIRST, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0};
        st.known[1] = '{2'd1, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0};
        st.known[2] = '{ROW_LAST, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1};
        plan.push_back(st);
        // all entries equal: rank one, adjugate zero
        st.q = {12{SAT_POS}};
        plan.push_back(st);
        st.q = {12{SAT_NEG}};
        plan.push_back(st);
        st.typed = 1'b0;
        st.q = diag(32'h0002_0000, 32'h0002_0000, 32'h0002_0000, SAT_POS);
        plan.push_back(st);
        st.q = diag(SAT_POS, SAT_POS, SAT_POS, SAT_NEG);
        plan.push_back(st);
        st.q = diag(SAT_NEG, SAT_NEG, SAT_NEG, SAT_POS);
        plan.push_back(st);
        st.q = diag(32'h1, 32'h1, 32'h1, 32'h0001_0000);
        plan.push_back(st);
        st.q = diag(-32'sh0001_0000, 32'h0003_0000, -32'sh0000_8000, 32'h0001_8000);
        plan.push_back(st);
        st.q = diag(SAT_NEG, SAT_POS, 32'h1, SAT_NEG);
        plan.push_back(st);
        for (int k = 0; k < 10; k++) begin
            st.q = rand_req(k);
            plan.push_back(st);
        end
        st.q = rand_req(8);
        st.q.tx = SAT_NEG; st.q.ty = SAT_POS; st.q.tz = SAT_NEG;
        plan.push_back(st);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) send_req(plan[k].q, plan[k].typed, plan[k].known);
        for (int n = 0; n < 500; n++) begin
            if (n == 450) quiet = 1'b1;
            q = rand_req($urandom_range(0, 9));
            send_req(q, 1'b0, st.known);
        end
        i_valid <= 1'b0;

        waited = 0;
        while (rows_due.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (60) @(posedge i_clk);

        if (rows_due.size() != 0) begin
            mismatches++;
            $display("%0d expected rows never arrived", rows_due.size());
        end
        $display("inverted %0d transforms (%0d singular), %0d rows checked, %0d mismatches",
                 plan.size() + 500, singular_seen, rows_seen, mismatches);
        if (mismatches == 0) begin
            $display("tb_affine_matrix_inverse OK");
        end else begin
            $display("tb_affine_matrix_inverse NOT OK");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ami_pkg.sv
rtl/ami_front.sv
rtl/ami_div.sv
rtl/affine_matrix_inverse.sv
tb/sv/tb_affine_matrix_inverse.sv
